// File: rtl/audio_dma_register_front_end_core_defines.svh
// Assertion macros for the audio DMA register front end.
`ifndef AUDIO_DMA_REGISTER_FRONT_END_CORE_DEFINES_SVH
`define AUDIO_DMA_REGISTER_FRONT_END_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ADRFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adrfe assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ADRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adrfe assertion failed: next-cycle check");

`else

`define ADRFE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ADRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/adrfe_pkg.sv
// Shared types and constants of the audio DMA register front end.
package adrfe_pkg;

    // Access direction
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register map (word index)
    localparam logic [2:0] REG_ADDR   = 3'd0;
    localparam logic [2:0] REG_LEN    = 3'd1;
    localparam logic [2:0] REG_CTRL   = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd3;
    localparam logic [2:0] REG_RATE   = 3'd4;

    // Rate register: default divider when written as zero, and divider field width
    localparam logic [31:0] RATE_DEFAULT = 32'd1100;
    localparam int          RATE_W       = 14;
    localparam int          PERIOD_W     = 15;

    // period = floor(d * CPU_CLOCK_HZ / VIDEO_CLOCK_HZ); both clocks share a factor of 48
    localparam logic [63:0] CPU_CLOCK_HZ   = 64'd93750000;
    localparam logic [63:0] VIDEO_CLOCK_HZ = 64'd48726144;
    localparam logic [63:0] CLOCK_GCD      = 64'd48;
    localparam logic [63:0] RATE_NUM       = CPU_CLOCK_HZ / CLOCK_GCD;
    localparam logic [63:0] RATE_DEN       = VIDEO_CLOCK_HZ / CLOCK_GCD;

    // Rounded-up reciprocal: exact floor for every d below 2^34 / RATE_DEN
    localparam int          RECIP_SHIFT = 34;
    localparam logic [63:0] RECIP       =
        ((RATE_NUM << RECIP_SHIFT) + RATE_DEN - 64'd1) / RATE_DEN;
    localparam int          RECIP_LO_W  = 17;
    localparam int          RECIP_HI_W  = 18;
    localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP[RECIP_LO_W-1:0];
    localparam logic [RECIP_HI_W-1:0] RECIP_HI =
        RECIP[RECIP_LO_W+RECIP_HI_W-1:RECIP_LO_W];

    // Result of the register decode stage
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        is_rate;
    } t_decode;

endpackage

// File: rtl/audio_dma_register_front_end_core.sv
// Top level of the audio DMA register front end: decode, state and result pipeline.
//
//   channel   direction  handshake            payload
//   access    in         i_valid / o_ready    i_cmd, i_reg_index, i_write_data
//   result    out        o_valid / i_ready    o_read_data, o_irq_pending, o_sample_period
//
// One access enters per cycle while o_ready is high; once taken, each access passes
// the capture register, decode stage and result register in that order.
// The rate conversion multiply is split in two partial products in the decode
// stage and recombined in front of the result register.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears buffer state,
// DMA enable, interrupt and sample period.
// Each stage holds while the stage after it is full and stalled; bubbles fill
// while the result side stalls, so o_ready drops only with all three stages full.

`include "audio_dma_register_front_end_core_defines.svh"

module audio_dma_register_front_end_core
    import adrfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  logic [2:0]          i_reg_index,
    input  logic [31:0]         i_write_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_read_data,
    output logic                o_irq_pending,
    output logic [PERIOD_W-1:0] o_sample_period
);

    // ---------------------------------------------------------------
    // Stage handshake: each stage advances when the next one has room
    // ---------------------------------------------------------------
    logic r_cap_valid, r_dec_valid, r_out_valid;
    logic adv_cap, adv_dec, adv_out;
    logic ld_dec, ld_out;

    assign adv_out = !r_out_valid || i_ready;
    assign adv_dec = !r_dec_valid || adv_out;
    assign adv_cap = !r_cap_valid || adv_dec;
    assign ld_dec  = r_cap_valid && adv_dec;
    assign ld_out  = r_dec_valid && adv_out;
    assign o_ready = adv_cap;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_valid <= 1'b0;
            r_dec_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_cap) begin
                r_cap_valid <= i_valid;
            end
            if (adv_dec) begin
                r_dec_valid <= r_cap_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_dec_valid;
            end
        end
    end

    // ---------------------------------------------------------------
    // Capture register: hold the accepted beat
    // ---------------------------------------------------------------
    logic        r_cmd;
    logic [2:0]  r_reg_index;
    logic [31:0] r_write_data;

    always_ff @(posedge i_clk) begin
        if (i_valid && adv_cap) begin
            r_cmd        <= i_cmd;
            r_reg_index  <= i_reg_index;
            r_write_data <= i_write_data;
        end
    end

    // ---------------------------------------------------------------
    // Decode stage: register access against the buffer state.
    // Only what reads can observe is kept: entry 0 length (bits 17:3),
    // both valid bits, DMA enable and the interrupt flag. Buffer
    // addresses and the second entry's length never reach a read.
    // ---------------------------------------------------------------
    logic [14:0] r_len0, n_len0;
    logic        r_valid0, n_valid0;
    logic        r_valid1, n_valid1;
    logic        r_dma_on, n_dma_on;
    logic        r_irq, n_irq;
    t_decode     n_dec, r_dec;
    logic [31:0] status_word;

    assign status_word = {r_valid1, r_valid0, 4'b0, r_dma_on, 1'b1, 3'b0, 1'b1,
                          19'b0, r_valid1};

    always_comb begin
        n_len0          = r_len0;
        n_valid0        = r_valid0;
        n_valid1        = r_valid1;
        n_dma_on        = r_dma_on;
        n_irq           = r_irq;
        n_dec.read_data = '0;
        n_dec.is_rate   = 1'b0;
        if (r_cmd == CMD_WRITE) begin
            unique case (r_reg_index)
                REG_LEN: begin
                    // fill entry 0 while free, else entry 1; only entry 0 interrupts
                    if (!r_valid0) begin
                        n_len0   = r_write_data[17:3];
                        n_valid0 = 1'b1;
                        n_irq    = 1'b1;
                    end else begin
                        n_valid1 = 1'b1;
                    end
                end
                REG_CTRL: begin
                    n_dma_on = r_write_data[0];
                end
                REG_STATUS: begin
                    n_irq = 1'b0;
                end
                REG_RATE: begin
                    n_dec.is_rate = 1'b1;
                end
                default: begin
                    // address and unused registers: nothing visible changes
                end
            endcase
        end else if (r_reg_index == REG_STATUS) begin
            n_dec.read_data = status_word;
        end else begin
            n_dec.read_data = {14'b0, r_len0, 3'b0};
        end
        n_dec.irq = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0   <= '0;
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
            r_dma_on <= 1'b0;
            r_irq    <= 1'b0;
        end else if (ld_dec) begin
            r_len0   <= n_len0;
            r_valid0 <= n_valid0;
            r_valid1 <= n_valid1;
            r_dma_on <= n_dma_on;
            r_irq    <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_dec) begin
            r_dec <= n_dec;
        end
    end

    // Rate conversion runs alongside; its partial products load with the decode stage
    logic [PERIOD_W-1:0] calc_period;

    adrfe_period_calc u_period_calc (
        .i_clk        (i_clk),
        .i_load       (ld_dec),
        .i_write_data (r_write_data),
        .o_period     (calc_period)
    );

    // ---------------------------------------------------------------
    // Result register: the sample period commits here, in access order
    // ---------------------------------------------------------------
    logic [PERIOD_W-1:0] r_period, n_period;

    assign n_period = r_dec.is_rate ? calc_period : r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
        end else if (ld_out) begin
            r_period <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            o_read_data     <= r_dec.read_data;
            o_irq_pending   <= r_dec.irq;
            o_sample_period <= n_period;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ADRFE_ASSERT_IMPL(a_fill_order, i_clk, i_rst_n, r_valid1, r_valid0)
    `ADRFE_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_ready,
        r_cap_valid && r_dec_valid && r_out_valid)
    `ADRFE_ASSERT_IMPL(a_period_shown, i_clk, i_rst_n, o_valid, o_sample_period == r_period)
    `ADRFE_ASSERT_NEXT(a_len_irq, i_clk, i_rst_n,
        ld_dec && r_cmd == CMD_WRITE && r_reg_index == REG_LEN && !r_valid0,
        r_irq && r_valid0)

endmodule

// File: rtl/adrfe_period_calc.sv
// Rate-to-sample-period conversion: split reciprocal multiply, then sum and shift.
module adrfe_period_calc
    import adrfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [31:0]         i_write_data,
    output logic [PERIOD_W-1:0] o_period
);

    localparam int HI_PROD_W = RATE_W + RECIP_HI_W;
    localparam int LO_PROD_W = RATE_W + RECIP_LO_W;
    localparam int SUM_W     = HI_PROD_W + RECIP_LO_W;

    logic [31:0]         rate_src;
    logic [RATE_W-1:0]   divider;
    logic [HI_PROD_W-1:0] n_prod_hi, r_prod_hi;
    logic [LO_PROD_W-1:0] n_prod_lo, r_prod_lo;
    logic [SUM_W-1:0]     prod_sum;

    assign rate_src  = (i_write_data == '0) ? RATE_DEFAULT : i_write_data;
    assign divider   = rate_src[RATE_W-1:0];
    assign n_prod_hi = {{RECIP_HI_W{1'b0}}, divider} * {{RATE_W{1'b0}}, RECIP_HI};
    assign n_prod_lo = {{RECIP_LO_W{1'b0}}, divider} * {{RATE_W{1'b0}}, RECIP_LO};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_hi <= n_prod_hi;
            r_prod_lo <= n_prod_lo;
        end
    end

    // recombine partial products and drop the fraction
    assign prod_sum = {r_prod_hi, {RECIP_LO_W{1'b0}}}
                    + {{(SUM_W-LO_PROD_W){1'b0}}, r_prod_lo};
    assign o_period = prod_sum[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];

endmodule
